// ===== design/inline_markup_tokenizer_assert.svh =====
// Assertion macros for the inline markup tokenizer.
// Included by inline_markup_tokenizer, which carries the concurrent checks; no other dependencies.
`ifndef INLINE_MARKUP_TOKENIZER_ASSERT_SVH
`define INLINE_MARKUP_TOKENIZER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define IMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("imt assertion failed");
// next-cycle implication
`define IMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("imt assertion failed");
`else
`define IMT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IMT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/imt_pkg.sv =====
// Shared types and constants for the inline markup tokenizer.
// No dependencies; imported by imt_decode, inline_markup_tokenizer and its testbench.
package imt_pkg;

    localparam int CP_W    = 21;
    localparam int STYLE_W = 6;
    localparam int KIND_W  = 2;

    // style bit positions
    localparam int BIT_BOLD  = 0;
    localparam int BIT_LARGE = 1;
    localparam int BIT_SUB   = 2;
    localparam int BIT_SUP   = 3;
    localparam int BIT_UNDER = 4;
    localparam int BIT_MONO  = 5;

    localparam logic [KIND_W-1:0] KIND_GLYPH   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPACE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEWLINE = 2'd2;

    localparam logic [CP_W-1:0] CP_TAB    = 21'h00009;
    localparam logic [CP_W-1:0] CP_LF     = 21'h0000A;
    localparam logic [CP_W-1:0] CP_SPACE  = 21'h00020;
    localparam logic [CP_W-1:0] CP_HASH   = 21'h00023;
    localparam logic [CP_W-1:0] CP_STAR   = 21'h0002A;
    localparam logic [CP_W-1:0] CP_BSLASH = 21'h0005C;
    localparam logic [CP_W-1:0] CP_CARET  = 21'h0005E;
    localparam logic [CP_W-1:0] CP_UNDER  = 21'h0005F;
    localparam logic [CP_W-1:0] CP_GRAVE  = 21'h00060;
    localparam logic [CP_W-1:0] CP_LBRACE = 21'h0007B;
    localparam logic [CP_W-1:0] CP_RBRACE = 21'h0007D;
    localparam logic [CP_W-1:0] CP_TILDE  = 21'h0007E;

    typedef struct packed {
        logic [STYLE_W-1:0] style;
        logic               esc;
        logic               skip;
    } t_state;

    typedef struct packed {
        logic               emit;
        logic [KIND_W-1:0]  kind;
        logic [CP_W-1:0]    code;
        logic [STYLE_W-1:0] style;
    } t_event;

endpackage

// ===== design/imt_decode.sv =====
// Per-character decode: classifies one code point against the current state,
// giving the event (if any) and the next state. Uses imt_pkg.
module imt_decode
    import imt_pkg::*;
(
    input  logic [CP_W-1:0] i_code_point,
    input  t_state          i_state,
    output t_event          o_event,
    output t_state          o_state
);

    logic [STYLE_W-1:0] toggle;
    logic               is_toggle;

    always_comb begin
        toggle    = '0;
        is_toggle = 1'b0;
        o_event   = '{emit: 1'b0, kind: KIND_GLYPH, code: '0, style: '0};
        o_state   = i_state;

        if (i_state.skip) begin
            // comment body: drop everything up to the first closing brace
            if (i_code_point == CP_RBRACE) begin
                o_state.skip = 1'b0;
            end
        end else begin
            o_state.esc = 1'b0;
            case (i_code_point)
                CP_STAR: begin
                    toggle[BIT_BOLD] = 1'b1;
                    is_toggle        = 1'b1;
                end
                CP_HASH: begin
                    toggle[BIT_LARGE] = 1'b1;
                    is_toggle         = 1'b1;
                end
                CP_TILDE: begin
                    toggle[BIT_UNDER] = 1'b1;
                    is_toggle         = 1'b1;
                end
                CP_GRAVE: begin
                    toggle[BIT_MONO] = 1'b1;
                    is_toggle        = 1'b1;
                end
                CP_UNDER: begin
                    toggle[BIT_SUB] = 1'b1;
                    is_toggle       = 1'b1;
                end
                CP_CARET: begin
                    toggle[BIT_SUP] = 1'b1;
                    is_toggle       = 1'b1;
                end
                CP_LBRACE: begin
                    if (i_state.esc) begin
                        o_event = '{emit: 1'b1, kind: KIND_GLYPH, code: i_code_point,
                                    style: i_state.style};
                    end else begin
                        o_state.skip = 1'b1;
                    end
                end
                CP_BSLASH: begin
                    if (i_state.esc) begin
                        o_event = '{emit: 1'b1, kind: KIND_GLYPH, code: i_code_point,
                                    style: i_state.style};
                    end else begin
                        o_state.esc = 1'b1;
                    end
                end
                CP_TAB, CP_SPACE: begin
                    o_event = '{emit: 1'b1, kind: KIND_SPACE, code: '0,
                                style: i_state.style};
                end
                CP_LF: begin
                    o_event = '{emit: 1'b1, kind: KIND_NEWLINE, code: '0, style: '0};
                    o_state.style[BIT_SUB] = 1'b0;
                    o_state.style[BIT_SUP] = 1'b0;
                end
                default: begin
                    // control characters below space are dropped
                    if (i_code_point > CP_SPACE) begin
                        o_event = '{emit: 1'b1, kind: KIND_GLYPH, code: i_code_point,
                                    style: i_state.style};
                    end
                end
            endcase

            if (is_toggle) begin
                if (i_state.esc) begin
                    o_event = '{emit: 1'b1, kind: KIND_GLYPH, code: i_code_point,
                                style: i_state.style};
                end else begin
                    // sub and sup exclude each other
                    if (toggle[BIT_SUB]) begin
                        o_state.style[BIT_SUP] = 1'b0;
                    end
                    if (toggle[BIT_SUP]) begin
                        o_state.style[BIT_SUB] = 1'b0;
                    end
                    o_state.style = o_state.style ^ toggle;
                end
            end
        end
    end

endmodule

// ===== design/inline_markup_tokenizer.sv =====
// Inline markup tokenizer: one code point in, at most one layout word out.
// A word is held in the input register; any token it gives is registered at the output.
// One word per cycle unless output stalls; the style/escape/skip flags update per word.
// Reset (i_rst_n low, synchronous) clears the flags and both valid registers.
// A word marked last returns the flags to their reset values once handled.
// Depends on imt_pkg, imt_decode and inline_markup_tokenizer_assert.svh.
`include "inline_markup_tokenizer_assert.svh"

module inline_markup_tokenizer
    import imt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CP_W-1:0]    i_in_code_point,
    input  logic               i_in_last_char,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [KIND_W-1:0]  o_out_event_kind,
    output logic [CP_W-1:0]    o_out_glyph_code,
    output logic [STYLE_W-1:0] o_out_style_bits
);

    logic               r_in_valid;
    logic               n_in_valid;
    logic [CP_W-1:0]    r_cp;
    logic               r_last;
    t_state             r_state;
    t_state             n_state;
    logic               r_out_valid;
    logic               n_out_valid;
    t_event             r_out;

    t_event             dec_event;
    t_state             dec_state;
    logic               in_acc;
    logic               adv;

    imt_decode u_decode (
        .i_code_point (r_cp),
        .i_state      (r_state),
        .o_event      (dec_event),
        .o_state      (dec_state)
    );

    // the held word moves on if it emits nothing or the result slot is free or not stalled
    assign adv        = r_in_valid && (!dec_event.emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (adv) begin
            n_in_valid = 1'b0;
            n_state    = r_last ? '0 : dec_state;
        end
        if (in_acc) begin
            n_in_valid = 1'b1;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (adv && dec_event.emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cp   <= i_in_code_point;
            r_last <= i_in_last_char;
        end
        if (adv && dec_event.emit) begin
            r_out <= dec_event;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_event_kind = r_out.kind;
    assign o_out_glyph_code = r_out.code;
    assign o_out_style_bits = r_out.style;

    `IMT_ASSERT_NOW(a_newline_clean, i_clk, i_rst_n,
        o_out_valid && (o_out_event_kind == KIND_NEWLINE),
        (o_out_style_bits == '0) && (o_out_glyph_code == '0))
    `IMT_ASSERT_NOW(a_space_no_code, i_clk, i_rst_n,
        o_out_valid && (o_out_event_kind == KIND_SPACE), o_out_glyph_code == '0)
    `IMT_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n,
        adv && r_last, r_state == '0)
    `IMT_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n,
        o_in_stall, r_in_valid && r_out_valid && i_out_stall && dec_event.emit)

endmodule

// ===== tb/inline_markup_tokenizer_tb.sv =====
// Self-checking testbench for the inline markup tokenizer: queue-fed driver, clocked monitor.
// Predicts each token in-bench from the style, escape and comment-skip flags.
// Depends on imt_pkg and the inline_markup_tokenizer RTL only.
`timescale 1ns / 100ps

module inline_markup_tokenizer_tb;
    import imt_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
    } t_char_word;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CP_W-1:0]    code;
        logic [STYLE_W-1:0] style;
    } t_token;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [CP_W-1:0]    i_in_code_point = '0;
    logic               i_in_last_char = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [KIND_W-1:0]  o_out_event_kind;
    logic [CP_W-1:0]    o_out_glyph_code;
    logic [STYLE_W-1:0] o_out_style_bits;

    t_char_word char_queue[$];
    t_token     expected_tokens[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         chars_queued = 0;

    // predictor state
    logic [STYLE_W-1:0] style_q = '0;
    logic               esc_q = 1'b0;
    logic               skip_q = 1'b0;

    logic [CP_W-1:0] markup_set[6] = '{CP_STAR, CP_HASH, CP_TILDE, CP_GRAVE, CP_UNDER, CP_CARET};

    inline_markup_tokenizer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_code_point  (i_in_code_point),
        .i_in_last_char   (i_in_last_char),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_event_kind (o_out_event_kind),
        .o_out_glyph_code (o_out_glyph_code),
        .o_out_style_bits (o_out_style_bits)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // recurring quiet stretches with no idling on either side; elsewhere each side idles at random
    function automatic logic take_break();
        if ((cycle_count % 1200) >= 900) begin
            return 1'b0;
        end
        return $urandom_range(99) < 34;
    endfunction

    function automatic void tokenize_char(input logic [CP_W-1:0] cp, input logic last,
                                          output logic fired, output t_token tok);
        logic               was_esc;
        logic [STYLE_W-1:0] flip;
        fired = 1'b0;
        tok = '0;
        flip = '0;
        was_esc = esc_q;
        if (skip_q) begin
            if (cp == CP_RBRACE) begin
                skip_q = 1'b0;
            end
        end else begin
            esc_q = 1'b0;
            case (cp)
                CP_STAR:  flip[BIT_BOLD] = 1'b1;
                CP_HASH:  flip[BIT_LARGE] = 1'b1;
                CP_TILDE: flip[BIT_UNDER] = 1'b1;
                CP_GRAVE: flip[BIT_MONO] = 1'b1;
                CP_UNDER: flip[BIT_SUB] = 1'b1;
                CP_CARET: flip[BIT_SUP] = 1'b1;
                CP_LBRACE, CP_BSLASH: begin
                    if (was_esc) begin
                        fired = 1'b1;
                        tok = '{KIND_GLYPH, cp, style_q};
                    end else if (cp == CP_LBRACE) begin
                        skip_q = 1'b1;
                    end else begin
                        esc_q = 1'b1;
                    end
                end
                CP_TAB, CP_SPACE: begin
                    fired = 1'b1;
                    tok = '{KIND_SPACE, '0, style_q};
                end
                CP_LF: begin
                    fired = 1'b1;
                    tok = '{KIND_NEWLINE, '0, '0};
                    style_q[BIT_SUB] = 1'b0;
                    style_q[BIT_SUP] = 1'b0;
                end
                default: begin
                    if (cp > CP_SPACE) begin
                        fired = 1'b1;
                        tok = '{KIND_GLYPH, cp, style_q};
                    end
                end
            endcase
            if (flip != '0) begin
                if (was_esc) begin
                    fired = 1'b1;
                    tok = '{KIND_GLYPH, cp, style_q};
                end else begin
                    // sub and sup exclude each other
                    if (flip[BIT_SUB]) style_q[BIT_SUP] = 1'b0;
                    if (flip[BIT_SUP]) style_q[BIT_SUB] = 1'b0;
                    style_q = style_q ^ flip;
                end
            end
        end
        if (last) begin
            style_q = '0;
            esc_q = 1'b0;
            skip_q = 1'b0;
        end
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        t_char_word word;
        t_token     tok;
        logic       fired;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                tokenize_char(i_in_code_point, i_in_last_char, fired, tok);
                if (fired) expected_tokens.push_back(tok);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (char_queue.size() > 0 && !take_break()) begin
                    word = char_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_code_point <= word.cp;
                    i_in_last_char <= word.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_tokens.size() == 0) begin
                    flag_mismatch($sformatf("unexpected token kind %0d code %h",
                                            o_out_event_kind, o_out_glyph_code));
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_out_event_kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, want %0d",
                                                o_out_event_kind, want.kind));
                    if (o_out_glyph_code !== want.code)
                        flag_mismatch($sformatf("code %h, want %h",
                                                o_out_glyph_code, want.code));
                    if (o_out_style_bits !== want.style)
                        flag_mismatch($sformatf("style %b, want %b",
                                                o_out_style_bits, want.style));
                end
            end
            i_out_stall <= take_break();
        end
    end

    task automatic queue_char(input logic [CP_W-1:0] cp, input logic last = 1'b0);
        char_queue.push_back('{cp, last});
        chars_queued++;
    endtask

    function automatic logic [CP_W-1:0] any_char();
        case ($urandom_range(3))
            0:       return CP_W'(CP_CARET + $urandom_range(32));
            1:       return CP_W'($urandom_range(21'h10FFFF, 1));
            default: return CP_W'($urandom_range(21'h7E, 21'h21));
        endcase
    endfunction

    function automatic logic [CP_W-1:0] any_markup();
        return markup_set[3'($urandom_range(5))];
    endfunction

    initial begin
        int r;
        int n;
        // directed opening
        queue_char(CP_STAR);
        queue_char(21'h41);
        queue_char(CP_HASH);
        queue_char(CP_TILDE);
        queue_char(CP_GRAVE);
        queue_char(CP_UNDER);
        queue_char(CP_CARET);     // sup on, sub off
        queue_char(CP_UNDER);
        queue_char(CP_SPACE);
        queue_char(CP_LF);        // drops sub/sup
        queue_char(CP_TAB);
        queue_char(CP_BSLASH);
        queue_char(CP_STAR);      // escaped markup prints
        queue_char(CP_BSLASH);
        queue_char(CP_BSLASH);
        queue_char(CP_BSLASH);
        queue_char(CP_LBRACE);
        queue_char(CP_RBRACE);    // plain glyph outside a comment
        queue_char(CP_LBRACE);
        queue_char(CP_STAR);
        queue_char(21'h10FFFF);
        queue_char(CP_RBRACE);
        queue_char(CP_BSLASH);
        queue_char(CP_LF);
        queue_char(21'h01);
        queue_char(CP_BSLASH);
        queue_char(21'h0FFFFF, 1'b1);
        queue_char(21'h1F);

        // random text built from well-formed pieces plus some noise
        while (chars_queued < 1030) begin
            r = $urandom_range(99);
            if (r < 35) begin
                queue_char(any_char());
            end else if (r < 55) begin
                queue_char(any_markup());
            end else if (r < 63) begin
                queue_char(CP_BSLASH);
                case ($urandom_range(3))
                    0:       queue_char(any_markup());
                    1:       queue_char(CP_LBRACE);
                    2:       queue_char(CP_BSLASH);
                    default: queue_char(any_char());
                endcase
            end else if (r < 70) begin
                queue_char(CP_LBRACE);
                n = $urandom_range(4);
                repeat (n) queue_char($urandom_range(1) ? any_markup() : any_char());
                queue_char(CP_RBRACE);
            end else if (r < 80) begin
                queue_char($urandom_range(1) ? CP_SPACE : CP_TAB);
            end else if (r < 86) begin
                queue_char(CP_LF);
            end else if (r < 91) begin
                queue_char(CP_W'($urandom_range(21'h1F, 1)));
            end else if (r < 92) begin
                queue_char(CP_LBRACE);    // possibly unterminated comment
            end else begin
                queue_char(CP_W'($urandom_range(21'h10FFFF, 1)));
            end
            if ($urandom_range(99) < 3) begin
                char_queue[$].last = 1'b1;
            end
        end

        wait (char_queue.size() == 0 && !i_in_valid && expected_tokens.size() == 0);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

endmodule
